// ===== design/running_average_background_subtractor_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RABS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion: when cond holds, prop must hold in the next cycle.
`define RABS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== design/rabs_pkg.sv =====
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared types, sizes and command codes of the background subtractor.
// ----------------------------------------------------------------------------
package rabs_pkg;

	localparam int PIXEL_COUNT      = 262144;
	localparam int IDX_W            = 18;
	localparam int MAX_LEARN_FRAMES = 64;
	localparam int CNT_W            = 7;
	localparam int FRAME_W          = 6;
	localparam int LIDX_W           = $clog2(MAX_LEARN_FRAMES);
	localparam int SUM_W            = 14;
	localparam int ALPHA_W          = 9;
	localparam int ALPHA_ONE        = 256;
	// floor(s*ceil(2^k/n) >> k) == floor(s/n) while 2^k >= s_max*n_max
	localparam int RECIP_SHIFT      = SUM_W + LIDX_W + 1;
	localparam int RECIP_W          = RECIP_SHIFT + 1;
	localparam int PROD_W           = SUM_W + RECIP_W;
	localparam int OUT_DEPTH        = 4;
	localparam int OUT_PTR_W        = 2;
	localparam int OUT_CNT_W        = 3;

	localparam logic [1:0] CMD_LEARN   = 2'd0;
	localparam logic [1:0] CMD_SUB     = 2'd1;
	localparam logic [1:0] CMD_UPDATE  = 2'd2;
	localparam logic [1:0] CMD_SUB_UPD = 2'd3;

	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_LEARN = 1'b1;

	typedef logic [2:0][7:0]       pix_t;
	typedef logic [2:0][SUM_W-1:0] sum_t;

	typedef struct packed {
		logic sum_we;
		logic bg_we;
		logic mean_sel;
		logic out;
		logic frame0;
	} ctl_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] n;
		n = raw;
		if (n == '0) n = CNT_W'(1);
		if (n > CNT_W'(MAX_LEARN_FRAMES)) n = CNT_W'(MAX_LEARN_FRAMES);
		return n;
	endfunction

	function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [ALPHA_W-1:0] raw);
		return (raw > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : raw;
	endfunction

endpackage

// ===== design/running_average_background_subtractor.sv =====
// ----------------------------------------------------------------------------
// running_average_background_subtractor
// Per-pixel RGB background learning, subtraction and running-average update.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while s_tready is high. Background and learn sums
// sit in two single-port-write, registered-read memories indexed by pixel;
// each beat reads at acceptance, computes in the next cycle and writes back
// from the stage-2 registers, with forwarding from the two most recent writes so
// that back-to-back hits on one pixel see fresh data. A difference beat passes
// the stage-1 and stage-2 registers into a four-entry output queue, which lets
// the input keep flowing while the output stalls; s_tready drops only when
// that queue and the results in flight would overflow it. No clearing pass:
// entries read before they are written return undefined data.
module running_average_background_subtractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_index[17:0], frame_number[23:18], red[31:24], green[39:32], blue[47:40]
	input  logic [47:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// diff_red[7:0], diff_green[15:8], diff_blue[23:16]
	output logic [23:0] m_tdata
);

	logic [rabs_pkg::ALPHA_W-1:0] alpha_q;
	logic [rabs_pkg::CNT_W-1:0]   learn_cnt_q;
	logic [rabs_pkg::CNT_W-1:0]   n_eff;
	logic [rabs_pkg::ALPHA_W-1:0] a_eff;
	logic [rabs_pkg::ALPHA_W-1:0] a_inv;
	logic [rabs_pkg::RECIP_W-1:0] recip_rom [rabs_pkg::MAX_LEARN_FRAMES];
	logic [rabs_pkg::RECIP_W-1:0] recip_q;

	rabs_pkg::sum_t sum_mem [rabs_pkg::PIXEL_COUNT];
	rabs_pkg::pix_t bg_mem  [rabs_pkg::PIXEL_COUNT];
	rabs_pkg::sum_t sum_rd_s1;
	rabs_pkg::pix_t bg_rd_s1;

	logic                       accept;
	logic [rabs_pkg::IDX_W-1:0] in_idx;
	logic [rabs_pkg::FRAME_W-1:0] in_frame;
	logic                       in_range;
	logic                       learn_ok;
	rabs_pkg::ctl_t             in_ctl;

	rabs_pkg::ctl_t             ctl_s1;
	logic [rabs_pkg::IDX_W-1:0] idx_s1;
	rabs_pkg::pix_t             px_s1;
	rabs_pkg::sum_t             sum_cur;
	rabs_pkg::pix_t             bg_cur;
	rabs_pkg::sum_t             sum_new;
	rabs_pkg::pix_t             diff_new;
	rabs_pkg::pix_t             blend_new;
	logic [2:0][rabs_pkg::PROD_W-1:0] prod_new;

	rabs_pkg::ctl_t             ctl_s2;
	logic [rabs_pkg::IDX_W-1:0] idx_s2;
	rabs_pkg::sum_t             sum_s2;
	rabs_pkg::pix_t             diff_s2;
	rabs_pkg::pix_t             blend_s2;
	logic [2:0][rabs_pkg::PROD_W-1:0] prod_s2;
	rabs_pkg::pix_t             bg_wd_s2;

	logic                       sum_we_s3;
	logic                       bg_we_s3;
	logic [rabs_pkg::IDX_W-1:0] idx_s3;
	rabs_pkg::sum_t             sum_s3;
	rabs_pkg::pix_t             bg_s3;

	rabs_pkg::pix_t             fifo_q [rabs_pkg::OUT_DEPTH];
	logic [rabs_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [rabs_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [rabs_pkg::OUT_CNT_W-1:0] count_q;
	logic [rabs_pkg::OUT_CNT_W-1:0] pending;
	logic                       pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= '0;
			learn_cnt_q <= rabs_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				rabs_pkg::REG_ALPHA: alpha_q     <= cfg_wdata;
				rabs_pkg::REG_LEARN: learn_cnt_q <= cfg_wdata[rabs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_eff = rabs_pkg::eff_count(learn_cnt_q);
	assign a_eff = rabs_pkg::eff_alpha(alpha_q);
	assign a_inv = rabs_pkg::ALPHA_W'(rabs_pkg::ALPHA_ONE) - a_eff;

	// reciprocal ceil(2^k / n) for n = g + 1
	for (genvar g = 0; g < rabs_pkg::MAX_LEARN_FRAMES; g++) begin : g_rcp
		localparam logic [rabs_pkg::RECIP_W-1:0] RecipVal = (rabs_pkg::RECIP_W)'(
			((2 ** rabs_pkg::RECIP_SHIFT) + g) / (g + 1));
		assign recip_rom[g] = RecipVal;
	end

	always_ff @(posedge clk) begin
		recip_q <= recip_rom[rabs_pkg::LIDX_W'(n_eff - rabs_pkg::CNT_W'(1))];
	end

	// accept stage: decode and issue memory reads
	assign accept   = s_tvalid & s_tready;
	assign in_idx   = s_tdata[rabs_pkg::IDX_W-1:0];
	assign in_frame = s_tdata[rabs_pkg::IDX_W +: rabs_pkg::FRAME_W];
	assign in_range = {1'b0, in_idx} < (rabs_pkg::IDX_W + 1)'(rabs_pkg::PIXEL_COUNT);
	assign learn_ok = (s_tuser == rabs_pkg::CMD_LEARN) && ({1'b0, in_frame} < n_eff);

	always_comb begin
		in_ctl.sum_we   = in_range & learn_ok;
		in_ctl.bg_we    = in_range & ((learn_ok &&
			({1'b0, in_frame} == n_eff - rabs_pkg::CNT_W'(1))) ||
			(s_tuser == rabs_pkg::CMD_UPDATE) || (s_tuser == rabs_pkg::CMD_SUB_UPD));
		in_ctl.mean_sel = s_tuser == rabs_pkg::CMD_LEARN;
		in_ctl.out      = in_range & ((s_tuser == rabs_pkg::CMD_SUB) ||
			(s_tuser == rabs_pkg::CMD_SUB_UPD));
		in_ctl.frame0   = in_frame == '0;
	end

	always_ff @(posedge clk) begin
		sum_rd_s1 <= sum_mem[in_idx];
		bg_rd_s1  <= bg_mem[in_idx];
		if (ctl_s2.sum_we) sum_mem[idx_s2] <= sum_s2;
		if (ctl_s2.bg_we)  bg_mem[idx_s2]  <= bg_wd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= accept ? in_ctl : '0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		px_s1  <= s_tdata[47:24];
	end

	// stage 1: forward, then compute sums, mean products, diff and blend
	always_comb begin
		if (ctl_s2.sum_we && idx_s2 == idx_s1) sum_cur = sum_s2;
		else if (sum_we_s3 && idx_s3 == idx_s1) sum_cur = sum_s3;
		else sum_cur = sum_rd_s1;
		if (ctl_s2.bg_we && idx_s2 == idx_s1) bg_cur = bg_wd_s2;
		else if (bg_we_s3 && idx_s3 == idx_s1) bg_cur = bg_s3;
		else bg_cur = bg_rd_s1;
	end

	always_comb begin
		logic [16:0] mix;
		for (int c = 0; c < 3; c++) begin
			sum_new[c] = ctl_s1.frame0 ? rabs_pkg::SUM_W'(px_s1[c])
				: sum_cur[c] + rabs_pkg::SUM_W'(px_s1[c]);
			prod_new[c] = rabs_pkg::PROD_W'(sum_new[c]) * rabs_pkg::PROD_W'(recip_q);
			diff_new[c] = (px_s1[c] >= bg_cur[c]) ? px_s1[c] - bg_cur[c]
				: bg_cur[c] - px_s1[c];
			mix = 17'(a_eff) * 17'(bg_cur[c]) + 17'(a_inv) * 17'(px_s1[c]);
			blend_new[c] = mix[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2   <= idx_s1;
		sum_s2   <= sum_new;
		prod_s2  <= prod_new;
		diff_s2  <= diff_new;
		blend_s2 <= blend_new;
	end

	// stage 2: finish the mean, select it or the blend, and write back
	always_comb begin
		logic [rabs_pkg::PROD_W-rabs_pkg::RECIP_SHIFT-1:0] q;
		for (int c = 0; c < 3; c++) begin
			q = prod_s2[c][rabs_pkg::PROD_W-1:rabs_pkg::RECIP_SHIFT];
			if (!ctl_s2.mean_sel) bg_wd_s2[c] = blend_s2[c];
			else if (q > 255) bg_wd_s2[c] = 8'hff;
			else bg_wd_s2[c] = q[7:0];
		end
	end

	// copy of the write landing this edge, missed by a read on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_we_s3 <= 1'b0;
			bg_we_s3  <= 1'b0;
		end else begin
			sum_we_s3 <= ctl_s2.sum_we;
			bg_we_s3  <= ctl_s2.bg_we;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		sum_s3 <= sum_s2;
		bg_s3  <= bg_wd_s2;
	end

	// output queue with credit for beats still in the pipeline
	assign pop      = m_tvalid & m_tready;
	assign m_tvalid = count_q != '0;
	assign m_tdata  = fifo_q[rd_ptr_q];
	assign pending  = count_q + rabs_pkg::OUT_CNT_W'(ctl_s1.out)
		+ rabs_pkg::OUT_CNT_W'(ctl_s2.out);
	assign s_tready = pending < rabs_pkg::OUT_CNT_W'(rabs_pkg::OUT_DEPTH);

	always_ff @(posedge clk) begin
		if (ctl_s2.out) fifo_q[wr_ptr_q] <= diff_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl_s2.out) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + rabs_pkg::OUT_CNT_W'(ctl_s2.out)
				- rabs_pkg::OUT_CNT_W'(pop);
		end
	end

endmodule

// ===== design/rabs_checker.sv =====
// ----------------------------------------------------------------------------
// rabs_checker
// Port-level checks of the background subtractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "running_average_background_subtractor_macros.svh"

module rabs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic in_beat;
	assign in_beat = s_tvalid & s_tready;

	`RABS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
	`RABS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "output data changed while stalled")
	// an output after an empty queue stems from an earlier accepted subtract beat
	`RABS_ASSERT(a_out_cause, clk, arst_n, $rose(m_tvalid) |-> $past(in_beat && s_tuser[0], 3), "output beat without a subtract beat")
	// nothing in flight and nothing queued: the input must be open
	`RABS_ASSERT(a_ready_idle, clk, arst_n, !m_tvalid && !$past(in_beat, 1) && !$past(in_beat, 2) |-> s_tready, "input closed while idle")

endmodule

bind running_average_background_subtractor rabs_checker u_rabs_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the background subtractor against a per-pixel model of learning,
// subtraction and blending. Beats go in as bursts with gaps, the output side
// stalls on its own pattern, and the configuration changes between phases.
// ----------------------------------------------------------------------------
module testbench;

	class bg_scoreboard;
		bit [7:0]  bg_mem [int][3];
		bit [13:0] sum_mem [int][3];
		bit        bg_written [int];
		bit        sum_written [int];
		bit [8:0]  alpha;
		bit [6:0]  learn_cnt;
		bit [23:0] diff_queue [$];
		int        errors;

		function int frames_used();
			int n;
			n = int'(learn_cnt);
			if (n == 0) n = 1;
			if (n > rabs_pkg::MAX_LEARN_FRAMES) n = rabs_pkg::MAX_LEARN_FRAMES;
			return n;
		endfunction

		function bit bg_ok(int idx);
			return bg_written.exists(idx);
		endfunction

		function bit sum_ok(int idx);
			return sum_written.exists(idx);
		endfunction

		function void note_pixel(bit [1:0] cmd, int idx, int frame, bit [7:0] px [3]);
			int n, a, c, b;
			bit [23:0] d;
			n = frames_used();
			if (cmd == rabs_pkg::CMD_LEARN) begin
				if (frame >= n) return;
				for (c = 0; c < 3; c++)
					sum_mem[idx][c] = (frame == 0) ? 14'(px[c])
						: sum_mem[idx][c] + 14'(px[c]);
				sum_written[idx] = 1;
				if (frame == n - 1) begin
					for (c = 0; c < 3; c++)
						bg_mem[idx][c] = 8'((sum_mem[idx][c] / n > 255) ? 255
							: sum_mem[idx][c] / n);
					bg_written[idx] = 1;
				end
				return;
			end
			if (cmd == rabs_pkg::CMD_SUB || cmd == rabs_pkg::CMD_SUB_UPD) begin
				for (c = 0; c < 3; c++) begin
					b = int'(bg_mem[idx][c]);
					d[c*8 +: 8] = (px[c] >= b) ? 8'(px[c] - b) : 8'(b - px[c]);
				end
				diff_queue.push_back(d);
			end
			if (cmd == rabs_pkg::CMD_UPDATE || cmd == rabs_pkg::CMD_SUB_UPD) begin
				a = (int'(alpha) > rabs_pkg::ALPHA_ONE) ? rabs_pkg::ALPHA_ONE : int'(alpha);
				for (c = 0; c < 3; c++)
					bg_mem[idx][c] = 8'((a * bg_mem[idx][c]
						+ (rabs_pkg::ALPHA_ONE - a) * px[c]) >> 8);
			end
		endfunction

		function void check_diff(bit [23:0] got);
			bit [23:0] want;
			if (diff_queue.size() == 0) begin
				$display("%0t: unexpected diff beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = diff_queue.pop_front();
			if (got[7:0] !== want[7:0] || got[15:8] !== want[15:8]
					|| got[23:16] !== want[23:16]) begin
				$display("%0t: diff mismatch, expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
					$time, want[7:0], want[15:8], want[23:16], got[7:0], got[15:8], got[23:16]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [8:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	bg_scoreboard sb;
	int           burst_left;
	int           cycle_cnt;
	int           rx_cnt;
	int           hold_off;
	bit           want_hold;
	int           pool [8];

	running_average_background_subtractor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: compare each beat, stall on a rotating pattern
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_diff(m_tdata);
	end

	always @(negedge clk) begin
		rx_cnt++;
		if (want_hold) begin
			want_hold = 0;
			hold_off  = 300;
		end
		if (hold_off > 0) begin
			hold_off--;
			m_tready = 1'b0;
		end else begin
			case ((rx_cnt / 64) % 4)
				0: m_tready = 1'b1;
				1: m_tready = ($urandom_range(0, 1) == 1);
				2: m_tready = ((rx_cnt % 4) == 0);
				default: m_tready = ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_pixel(bit [1:0] cmd, int idx, int frame, bit [7:0] px [3]);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {px[2], px[1], px[0], 6'(frame), 18'(idx)};
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(cmd, idx, frame, px);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_reg(logic addr, int val);
		cfg_we    = 1'b1;
		cfg_addr  = addr;
		cfg_wdata = 9'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == rabs_pkg::REG_ALPHA) sb.alpha = 9'(val);
		else sb.learn_cnt = 7'(val);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.diff_queue.size() != 0) @(negedge clk);
		// learn and update beats may still be writing back
		repeat (10) @(negedge clk);
	endtask

	function automatic bit [7:0] chan_val();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_pixel();
		bit [7:0] px [3];
		int idx, frame, n;
		bit [1:0] cmd;
		n   = sb.frames_used();
		idx = pool[$urandom_range(0, 7)];
		foreach (px[c]) px[c] = chan_val();
		frame = 0;
		if ($urandom_range(0, 99) < 15) begin
			cmd   = rabs_pkg::CMD_LEARN;
			frame = $urandom_range(0, (n + 2 > 63) ? 63 : n + 2);
			if (frame > 0 && frame < n && !sb.sum_ok(idx)) frame = 0;
		end else begin
			cmd = 2'($urandom_range(1, 3));
			if (!sb.bg_ok(idx)) cmd = rabs_pkg::CMD_LEARN;
		end
		push_pixel(cmd, idx, frame, px);
	endtask

	task automatic learn_pass();
		bit [7:0] px [3];
		int n, np;
		n  = sb.frames_used();
		np = (n <= 8) ? 8 : 3;
		for (int f = 0; f < n; f++)
			for (int p = 0; p < np; p++) begin
				foreach (px[c]) px[c] = chan_val();
				push_pixel(rabs_pkg::CMD_LEARN, pool[p], f, px);
			end
	endtask

	initial begin
		bit [7:0] lo [3];
		bit [7:0] hi [3];
		bit [7:0] mid [3];
		int alphas [8];
		int counts [8];
		sb = new();
		sb.learn_cnt = 1;
		lo  = '{8'd0, 8'd0, 8'd0};
		hi  = '{8'd255, 8'd255, 8'd255};
		mid = '{8'd17, 8'd128, 8'd240};
		alphas = '{0, 256, 511, 37, 200, 128, 0, 0};
		counts = '{1, 64, 2, 0, 127, 3, 0, 0};
		alphas[6] = $urandom_range(0, 511);
		alphas[7] = $urandom_range(0, 256);
		counts[6] = $urandom_range(1, 8);
		counts[7] = $urandom_range(1, 8);
		pool = '{0, 262143, 1, 131072, 0, 0, 0, 0};
		for (int i = 4; i < 8; i++) pool[i] = $urandom_range(0, rabs_pkg::PIXEL_COUNT - 1);
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_addr = rabs_pkg::REG_ALPHA; cfg_wdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = rabs_pkg::CMD_LEARN;
		m_tready = 1'b1;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: default count of one, alpha zero
		push_pixel(rabs_pkg::CMD_LEARN, 0, 0, lo);
		push_pixel(rabs_pkg::CMD_LEARN, 262143, 0, hi);
		push_pixel(rabs_pkg::CMD_SUB, 0, 0, hi);
		push_pixel(rabs_pkg::CMD_SUB, 262143, 0, lo);
		push_pixel(rabs_pkg::CMD_SUB, 262143, 0, hi);
		push_pixel(rabs_pkg::CMD_LEARN, 0, 5, hi);          // late frame, dropped
		push_pixel(rabs_pkg::CMD_SUB, 0, 0, mid);
		push_pixel(rabs_pkg::CMD_UPDATE, 0, 0, mid);        // alpha 0 takes the pixel
		push_pixel(rabs_pkg::CMD_SUB_UPD, 0, 0, hi);
		push_pixel(rabs_pkg::CMD_SUB, 0, 0, lo);
		push_pixel(rabs_pkg::CMD_SUB_UPD, 262143, 63, lo);
		push_pixel(rabs_pkg::CMD_SUB, 262143, 0, hi);
		drain();
		write_reg(rabs_pkg::REG_ALPHA, 256);
		write_reg(rabs_pkg::REG_LEARN, 2);
		push_pixel(rabs_pkg::CMD_LEARN, 0, 0, hi);
		push_pixel(rabs_pkg::CMD_LEARN, 0, 1, hi);
		push_pixel(rabs_pkg::CMD_LEARN, 0, 1, hi);          // repeated frame, sum past 8 bits
		push_pixel(rabs_pkg::CMD_SUB_UPD, 0, 0, lo);        // alpha one keeps background
		push_pixel(rabs_pkg::CMD_SUB, 0, 0, mid);
		push_pixel(rabs_pkg::CMD_LEARN, 0, 2, lo);          // late frame
		push_pixel(rabs_pkg::CMD_SUB, 0, 0, lo);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(rabs_pkg::REG_ALPHA, alphas[ph]);
			write_reg(rabs_pkg::REG_LEARN, counts[ph]);
			pool[7] = $urandom_range(0, rabs_pkg::PIXEL_COUNT - 1);
			learn_pass();
			for (int i = 0; i < 150; i++) begin
				if (ph == 2 && i == 20) want_hold = 1;
				random_pixel();
			end
			drain();
		end

		s_tvalid = 1'b0;
		while (sb.diff_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
